// File: hdl/entity_id_allocator_with_masks_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the entity identifier allocator
// Shared property forms, sampled on the rising clock edge.
// The properties are disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ENTITY_ID_ALLOCATOR_WITH_MASKS_DEFINES_SVH
`define ENTITY_ID_ALLOCATOR_WITH_MASKS_DEFINES_SVH

// Same-cycle implication.
`define EIA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("eia: assertion failed");

// Next-cycle implication.
`define EIA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("eia: assertion failed");

`endif

// File: hdl/eia_pkg.sv
// ----------------------------------------------------------------------------
// eia_pkg
// Types and constants for the entity identifier allocator.
// ----------------------------------------------------------------------------
package eia_pkg;

  localparam int MAX_IDS        = 256;
  localparam int ID_W           = $clog2(MAX_IDS);
  localparam int NUM_COMPONENTS = 32;
  localparam int MASK_W         = NUM_COMPONENTS;
  localparam int COMP_W         = 5;
  localparam int CNT_W          = ID_W;
  localparam int FREE_CNT_W     = ID_W + 1;
  localparam int KIND_W         = 2;

  // Input tdata layout
  localparam int IN_ID_LSB   = 0;
  localparam int IN_COMP_LSB = IN_ID_LSB + ID_W;
  localparam int IN_HAS_LSB  = IN_COMP_LSB + COMP_W;
  localparam int IN_BITS     = IN_HAS_LSB + 1;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;

  // Output tdata layout
  localparam int OUT_ID_LSB     = 0;
  localparam int OUT_MASK_LSB   = OUT_ID_LSB + ID_W;
  localparam int OUT_TOTAL_LSB  = OUT_MASK_LSB + MASK_W;
  localparam int OUT_ACTIVE_LSB = OUT_TOTAL_LSB + CNT_W;
  localparam int OUT_BITS       = OUT_ACTIVE_LSB + CNT_W;
  localparam int OUT_DATA_W     = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_IDS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_CREATE  = 2'd0,
    KIND_DESTROY = 2'd1,
    KIND_SET     = 2'd2,
    KIND_GET     = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e             kind;
    logic [ID_W-1:0]   entity_id;
    logic [COMP_W-1:0] component_index;
    logic              has_component;
  } in_item_t;

endpackage

// File: hdl/entity_id_allocator_with_masks.sv
// ----------------------------------------------------------------------------
// entity_id_allocator_with_masks
// Identifier allocator with a free list and a component mask per identifier.
// ----------------------------------------------------------------------------
// Accepts one transaction per clock unless the output stalls, and returns
// exactly one result per transaction. Each transaction is registered, then
// resolved in a single pass against the valid-bit flops, the mask memory and
// the free-list memory, and the result lands in an output register. Both
// memories have a registered read port; a write made by the transaction ahead
// is forwarded to the one behind, which sets the one-per-cycle figure. Valid
// bits are flops cleared by reset, so no clearing pass is needed and
// transactions are taken right after reset.
module entity_id_allocator_with_masks (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // entity_id, component_index, has_component (lowest bit first)
  input  logic [eia_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [eia_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // result_id, mask_value, total_created, active_count (lowest bit first)
  output logic [eia_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // ok
  output logic [0:0]                     m_axis_tuser
);

  eia_pkg::in_item_t in_item;
  logic              in_fire;

  logic              s1_valid_q;
  eia_pkg::in_item_t s1_item_q;
  logic              s1_fire;

  logic [eia_pkg::MAX_IDS-1:0]    valid_q, valid_d;
  logic [eia_pkg::ID_W-1:0]       free_head_q, free_head_d;
  logic [eia_pkg::ID_W-1:0]       free_tail_q, free_tail_d;
  logic [eia_pkg::FREE_CNT_W-1:0] free_count_q, free_count_d;
  logic [eia_pkg::CNT_W-1:0]      issued_q, issued_d;
  logic [eia_pkg::CNT_W-1:0]      live_q, live_d;

  logic [eia_pkg::MASK_W-1:0] mask_mem [eia_pkg::MAX_IDS];
  logic [eia_pkg::MASK_W-1:0] mask_rd_q;
  logic                       mask_fwd_q;
  logic [eia_pkg::MASK_W-1:0] mask_fwd_data_q;
  logic [eia_pkg::MASK_W-1:0] mask_rd;
  logic                       mask_we;
  logic [eia_pkg::ID_W-1:0]   mask_waddr;
  logic [eia_pkg::MASK_W-1:0] mask_wdata;

  logic [eia_pkg::ID_W-1:0] fifo_mem [eia_pkg::MAX_IDS];
  logic [eia_pkg::ID_W-1:0] fifo_rd_q;
  logic                     fifo_fwd_q;
  logic [eia_pkg::ID_W-1:0] fifo_fwd_data_q;
  logic [eia_pkg::ID_W-1:0] head_data;
  logic                     fifo_we;

  logic                       id_ok;
  logic [eia_pkg::ID_W-1:0]   res_id;
  logic [eia_pkg::MASK_W-1:0] mask_out;
  logic                       ok;
  logic [eia_pkg::MASK_W-1:0] comp_bit;

  logic                           out_valid_q, out_valid_d;
  logic [eia_pkg::OUT_DATA_W-1:0] out_data_q;
  logic                           out_ok_q;

  assign in_item.kind            = eia_pkg::kind_e'(s_axis_tuser);
  assign in_item.entity_id       = s_axis_tdata[eia_pkg::IN_ID_LSB +: eia_pkg::ID_W];
  assign in_item.component_index = s_axis_tdata[eia_pkg::IN_COMP_LSB +: eia_pkg::COMP_W];
  assign in_item.has_component   = s_axis_tdata[eia_pkg::IN_HAS_LSB];

  assign s1_fire       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign mask_rd   = mask_fwd_q ? mask_fwd_data_q : mask_rd_q;
  assign head_data = fifo_fwd_q ? fifo_fwd_data_q : fifo_rd_q;
  assign id_ok     = (s1_item_q.entity_id != '0) && valid_q[s1_item_q.entity_id];
  assign comp_bit  = eia_pkg::MASK_W'(1) << s1_item_q.component_index;

  always_comb begin
    valid_d      = valid_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_count_d = free_count_q;
    issued_d     = issued_q;
    live_d       = live_q;
    res_id       = s1_item_q.entity_id;
    mask_out     = '0;
    ok           = 1'b0;
    mask_we      = 1'b0;
    mask_waddr   = s1_item_q.entity_id;
    mask_wdata   = '0;
    fifo_we      = 1'b0;
    if (s1_fire) begin
      case (s1_item_q.kind)
        eia_pkg::KIND_CREATE: begin
          res_id = '0;
          if (free_count_q != '0) begin
            res_id       = head_data;
            free_head_d  = free_head_q + eia_pkg::ID_W'(1);
            free_count_d = free_count_q - eia_pkg::FREE_CNT_W'(1);
            ok           = 1'b1;
          end else if (issued_q != eia_pkg::LAST_ID) begin
            issued_d = issued_q + eia_pkg::CNT_W'(1);
            res_id   = issued_d;
            ok       = 1'b1;
          end
          if (ok) begin
            valid_d[res_id] = 1'b1;
            mask_we         = 1'b1;
            mask_waddr      = res_id;
            live_d          = live_q + eia_pkg::CNT_W'(1);
          end
        end
        eia_pkg::KIND_DESTROY: begin
          ok = id_ok;
          if (id_ok) begin
            valid_d[s1_item_q.entity_id] = 1'b0;
            fifo_we      = 1'b1;
            free_tail_d  = free_tail_q + eia_pkg::ID_W'(1);
            free_count_d = free_count_q + eia_pkg::FREE_CNT_W'(1);
            live_d       = live_q - eia_pkg::CNT_W'(1);
          end
        end
        eia_pkg::KIND_SET: begin
          ok = id_ok;
          if (id_ok && (32'(s1_item_q.component_index) < eia_pkg::NUM_COMPONENTS)) begin
            mask_we    = 1'b1;
            mask_wdata = s1_item_q.has_component ? (mask_rd | comp_bit)
                                                 : (mask_rd & ~comp_bit);
          end
        end
        eia_pkg::KIND_GET: begin
          ok = id_ok;
          if (id_ok) begin
            mask_out = mask_rd;
          end
        end
        default: begin
          ok = 1'b0;
        end
      endcase
    end
  end

  // mask memory, read for the incoming transaction, forwarding the write ahead
  always_ff @(posedge clk_i) begin
    if (mask_we) begin
      mask_mem[mask_waddr] <= mask_wdata;
    end
    if (in_fire) begin
      mask_rd_q       <= mask_mem[in_item.entity_id];
      mask_fwd_q      <= mask_we && (mask_waddr == in_item.entity_id);
      mask_fwd_data_q <= mask_wdata;
    end
  end

  // free list, head entry prefetched every cycle
  always_ff @(posedge clk_i) begin
    if (fifo_we) begin
      fifo_mem[free_tail_q] <= s1_item_q.entity_id;
    end
    fifo_rd_q       <= fifo_mem[free_head_d];
    fifo_fwd_q      <= fifo_we && (free_tail_q == free_head_d);
    fifo_fwd_data_q <= s1_item_q.entity_id;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      valid_q      <= '0;
      free_head_q  <= '0;
      free_tail_q  <= '0;
      free_count_q <= '0;
      issued_q     <= '0;
      live_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      s1_valid_q   <= in_fire || (s1_valid_q && !s1_fire);
      valid_q      <= valid_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_count_q <= free_count_d;
      issued_q     <= issued_d;
      live_q       <= live_d;
      out_valid_q  <= out_valid_d;
    end
  end

  assign out_valid_d = s1_fire || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_item_q <= in_item;
    end
    if (s1_fire) begin
      out_data_q <= eia_pkg::OUT_DATA_W'({live_d, issued_d, mask_out, res_id});
      out_ok_q   <= ok;
    end
  end

  assign m_axis_tvalid   = out_valid_q;
  assign m_axis_tdata    = out_data_q;
  assign m_axis_tuser[0] = out_ok_q;

endmodule

// File: hdl/eia_checker.sv
// ----------------------------------------------------------------------------
// eia_checker
// Port-level checks for the entity identifier allocator, bound to the top.
// ----------------------------------------------------------------------------
`include "entity_id_allocator_with_masks_defines.svh"

module eia_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [eia_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  input logic [eia_pkg::KIND_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [eia_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  logic [eia_pkg::ID_W-1:0]   out_id;
  logic [eia_pkg::MASK_W-1:0] out_mask;
  logic [eia_pkg::CNT_W-1:0]  out_total;
  logic [eia_pkg::CNT_W-1:0]  out_active;
  logic                       in_fire;

  assign out_id     = m_axis_tdata[eia_pkg::OUT_ID_LSB +: eia_pkg::ID_W];
  assign out_mask   = m_axis_tdata[eia_pkg::OUT_MASK_LSB +: eia_pkg::MASK_W];
  assign out_total  = m_axis_tdata[eia_pkg::OUT_TOTAL_LSB +: eia_pkg::CNT_W];
  assign out_active = m_axis_tdata[eia_pkg::OUT_ACTIVE_LSB +: eia_pkg::CNT_W];
  assign in_fire    = s_axis_tvalid && s_axis_tready && (s_axis_tdata != '1 || s_axis_tuser != '1);

  `EIA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `EIA_ASSERT_IMP(a_fail_no_mask, clk_i, rst_ni, m_axis_tvalid && !m_axis_tuser[0], out_mask == '0)
  `EIA_ASSERT_IMP(a_ok_nonzero_id, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0], out_id != '0)
  `EIA_ASSERT_IMP(a_live_bound, clk_i, rst_ni, m_axis_tvalid || in_fire, !m_axis_tvalid || (out_active <= out_total))

endmodule

bind entity_id_allocator_with_masks eia_checker u_eia_checker (.*);

// File: verif/entity_id_allocator_with_masks_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entity_id_allocator_with_masks_tb
// Self-checking bench for the identifier allocator with component masks.
// ----------------------------------------------------------------------------
// A behavioral copy of the allocator (valid bits, masks, free-list ring and
// counters) predicts every result when its transaction is accepted. Results
// are checked in order, field by field. Stimulus is a directed pass over
// create, destroy, set and get, including invalid identifiers and free-list
// reuse, then a long random mix aimed mostly at live identifiers, then a run
// that fills the whole identifier space, tries creates when full, then a mix.
// The sender idles in random bursts; the receiver stalls on its own schedule.
// ----------------------------------------------------------------------------
module entity_id_allocator_with_masks_tb;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int DRAIN_CYCLES = 8;
  localparam int SHOWN_MISMATCHES = 10;

  typedef struct {
    logic [eia_pkg::ID_W-1:0]   id;
    logic [eia_pkg::MASK_W-1:0] mask;
    logic                       ok;
    logic [eia_pkg::CNT_W-1:0]  total;
    logic [eia_pkg::CNT_W-1:0]  active;
  } result_t;

  typedef enum int {
    READY_ALWAYS,
    READY_MOSTLY,
    READY_COIN,
    READY_PERIODIC
  } stall_mode_e;

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [eia_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [eia_pkg::KIND_W-1:0]     s_axis_tuser = eia_pkg::KIND_CREATE;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b1;
  logic [eia_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [0:0]                     m_axis_tuser;

  // Allocator state as predicted
  logic                           mdl_valid [eia_pkg::MAX_IDS] = '{default: 1'b0};
  logic [eia_pkg::MASK_W-1:0]     mdl_mask [eia_pkg::MAX_IDS] = '{default: '0};
  logic [eia_pkg::ID_W-1:0]       mdl_free_ring [eia_pkg::MAX_IDS] = '{default: '0};
  logic [eia_pkg::ID_W-1:0]       mdl_free_head = '0;
  logic [eia_pkg::ID_W-1:0]       mdl_free_tail = '0;
  logic [eia_pkg::FREE_CNT_W-1:0] mdl_free_cnt = '0;
  logic [eia_pkg::CNT_W-1:0]      mdl_issued = '0;
  logic [eia_pkg::CNT_W-1:0]      mdl_live = '0;

  result_t pending_results [$];

  int kind_count [4] = '{default: 0};
  int n_checked = 0;
  int n_reused = 0;
  int n_full_creates = 0;
  int n_bad_id_ops = 0;
  int mismatches = 0;
  int cycle_cnt = 0;
  int burst_left = 0;
  int stall_left = 0;
  stall_mode_e stall_mode = READY_ALWAYS;

  entity_id_allocator_with_masks DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // Updates the predicted state and returns the result of one transaction.
  function automatic result_t predict_alloc(eia_pkg::in_item_t op);
    result_t r;
    logic [eia_pkg::ID_W-1:0] id;
    r.id   = op.entity_id;
    r.mask = '0;
    r.ok   = 1'b0;
    if (op.kind == eia_pkg::KIND_CREATE) begin
      r.id = '0;
      if (mdl_free_cnt != 0) begin
        id = mdl_free_ring[mdl_free_head];
        mdl_free_head++;
        mdl_free_cnt--;
        r.ok = 1'b1;
        r.id = id;
        n_reused++;
      end else if (mdl_issued != eia_pkg::LAST_ID) begin
        mdl_issued++;
        r.ok = 1'b1;
        r.id = mdl_issued;
      end else begin
        n_full_creates++;
      end
      if (r.ok) begin
        mdl_valid[r.id] = 1'b1;
        mdl_mask[r.id]  = '0;
        mdl_live++;
      end
    end else if (op.entity_id != '0 && mdl_valid[op.entity_id]) begin
      id   = op.entity_id;
      r.ok = 1'b1;
      case (op.kind)
        eia_pkg::KIND_DESTROY: begin
          mdl_valid[id] = 1'b0;
          mdl_mask[id]  = '0;
          mdl_free_ring[mdl_free_tail] = id;
          mdl_free_tail++;
          mdl_free_cnt++;
          mdl_live--;
        end
        eia_pkg::KIND_SET: begin
          if (op.component_index < eia_pkg::NUM_COMPONENTS)
            mdl_mask[id][op.component_index] = op.has_component;
        end
        default: begin
          r.mask = mdl_mask[id];
        end
      endcase
    end else begin
      n_bad_id_ops++;
    end
    r.total  = mdl_issued;
    r.active = mdl_live;
    return r;
  endfunction

  function automatic logic [eia_pkg::ID_W-1:0] pick_live_id();
    logic [eia_pkg::ID_W-1:0] cand;
    cand = eia_pkg::ID_W'($urandom);
    for (int i = 0; i < eia_pkg::MAX_IDS; i++) begin
      if (cand != '0 && mdl_valid[cand])
        return cand;
      cand++;
    end
    return eia_pkg::ID_W'($urandom);
  endfunction

  task automatic log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= SHOWN_MISMATCHES)
      $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic enqueue_result(input result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Sends one transaction; the sender idles between bursts of random length.
  task automatic send_op(input eia_pkg::kind_e k, input logic [eia_pkg::ID_W-1:0] id,
                         input logic [eia_pkg::COMP_W-1:0] comp, input logic has);
    eia_pkg::in_item_t             op;
    logic [eia_pkg::IN_DATA_W-1:0] packed_data;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
    end
    op.kind            = k;
    op.entity_id       = id;
    op.component_index = comp;
    op.has_component   = has;
    packed_data = '0;
    packed_data[eia_pkg::IN_ID_LSB +: eia_pkg::ID_W]     = id;
    packed_data[eia_pkg::IN_COMP_LSB +: eia_pkg::COMP_W] = comp;
    packed_data[eia_pkg::IN_HAS_LSB]                     = has;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= packed_data;
    s_axis_tuser  <= k;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    enqueue_result(predict_alloc(op));
    kind_count[k]++;
    burst_left--;
  endtask

  task automatic random_op(input int create_pct);
    eia_pkg::kind_e k;
    logic [eia_pkg::ID_W-1:0] id;
    k = ($urandom_range(0, 99) < create_pct) ? eia_pkg::KIND_CREATE
                                              : eia_pkg::kind_e'($urandom_range(1, 3));
    id = ($urandom_range(0, 99) < 85) ? pick_live_id() : eia_pkg::ID_W'($urandom);
    send_op(k, id, eia_pkg::COMP_W'($urandom), 1'($urandom));
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      READY_ALWAYS:   m_axis_tready <= 1'b1;
      READY_MOSTLY:   m_axis_tready <= ($urandom_range(0, 3) != 0);
      READY_COIN:     m_axis_tready <= 1'($urandom);
      default:        m_axis_tready <= ((stall_left % 7) < 3);
    endcase
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.id     = m_axis_tdata[eia_pkg::OUT_ID_LSB +: eia_pkg::ID_W];
      got.mask   = m_axis_tdata[eia_pkg::OUT_MASK_LSB +: eia_pkg::MASK_W];
      got.total  = m_axis_tdata[eia_pkg::OUT_TOTAL_LSB +: eia_pkg::CNT_W];
      got.active = m_axis_tdata[eia_pkg::OUT_ACTIVE_LSB +: eia_pkg::CNT_W];
      got.ok     = m_axis_tuser[0];
      n_checked++;
      if (pending_results.size() == 0) begin
        log_mismatch($sformatf("unexpected result id=%0d ok=%0b", got.id, got.ok));
      end else begin
        want = pending_results.pop_front();
        if (got.id !== want.id || got.mask !== want.mask || got.ok !== want.ok ||
            got.total !== want.total || got.active !== want.active)
          log_mismatch($sformatf(
            {"exp id=%0d mask=%h ok=%0b total=%0d active=%0d, ",
             "got id=%0d mask=%h ok=%0b total=%0d active=%0d"},
            want.id, want.mask, want.ok, want.total, want.active,
            got.id, got.mask, got.ok, got.total, got.active));
      end
    end
  end

  task automatic test_directed_ops();
    send_op(eia_pkg::KIND_CREATE,  8'd255, 5'd31, 1'b1);
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_GET,     8'd1,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_SET,     8'd1,   5'd0,  1'b1);
    send_op(eia_pkg::KIND_SET,     8'd1,   5'd31, 1'b1);
    send_op(eia_pkg::KIND_GET,     8'd1,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_SET,     8'd1,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_GET,     8'd1,   5'd0,  1'b0);
    // identifier zero and never-issued identifiers are invalid
    send_op(eia_pkg::KIND_GET,     8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_DESTROY, 8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_SET,     8'd0,   5'd5,  1'b1);
    send_op(eia_pkg::KIND_GET,     8'd255, 5'd31, 1'b1);
    send_op(eia_pkg::KIND_SET,     8'd2,   5'd7,  1'b1);
    send_op(eia_pkg::KIND_SET,     8'd2,   5'd31, 1'b1);
    send_op(eia_pkg::KIND_DESTROY, 8'd2,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_DESTROY, 8'd2,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_GET,     8'd2,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_SET,     8'd2,   5'd3,  1'b1);
    // reuse must hand back 2 with a cleared mask
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_GET,     8'd2,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_DESTROY, 8'd1,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_DESTROY, 8'd3,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
    send_op(eia_pkg::KIND_CREATE,  8'd0,   5'd0,  1'b0);
  endtask

  task automatic test_random_mix(input int n_items);
    int create_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0)
        create_pct = $urandom_range(15, 45);
      random_op(create_pct);
    end
  endtask

  task automatic test_full_space(input int n_after);
    while (!(mdl_free_cnt == 0 && mdl_issued == eia_pkg::LAST_ID))
      send_op(eia_pkg::KIND_CREATE, eia_pkg::ID_W'($urandom),
              eia_pkg::COMP_W'($urandom), 1'($urandom));
    repeat (4)
      send_op(eia_pkg::KIND_CREATE, eia_pkg::ID_W'($urandom),
              eia_pkg::COMP_W'($urandom), 1'($urandom));
    for (int i = 0; i < n_after; i++)
      random_op(30);
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_ops();
    test_random_mix(1000);
    test_full_space(60);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pending_results.size() != 0)
      log_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    $display("ran %0d create, %0d destroy, %0d set, %0d get; %0d results checked",
             kind_count[eia_pkg::KIND_CREATE], kind_count[eia_pkg::KIND_DESTROY],
             kind_count[eia_pkg::KIND_SET], kind_count[eia_pkg::KIND_GET], n_checked);
    $display("free-list reuses %0d, creates with no identifier left %0d, invalid-id ops %0d",
             n_reused, n_full_creates, n_bad_id_ops);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
